[rtl/clfp_pkg.sv]
// ----------------------------------------------------------------------------
// clfp_pkg
// Opcodes, status codes and the command and status structs shared by the
// controller and the datapath of the linked list free pool unit.
// ----------------------------------------------------------------------------
package clfp_pkg;

  localparam int OP_W = 3;
  localparam int ST_W = 2;

  // opcodes
  localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd1;
  localparam logic [OP_W-1:0] OP_LOCATE   = 3'd2;
  localparam logic [OP_W-1:0] OP_RETRIEVE = 3'd3;
  localparam logic [OP_W-1:0] OP_NEXT     = 3'd4;
  localparam logic [OP_W-1:0] OP_PREV     = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD     = 3'd7;

  // status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_POS   = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_POOL_FULL = 2'd3;

  // datapath selects
  typedef enum logic [2:0] {CUR_HOLD, CUR_HEAD, CUR_INC, CUR_LINK, CUR_FREE} cur_sel_t;
  typedef enum logic [1:0] {RA_HEAD, RA_LINK, RA_POS, RA_FREE} rd_sel_t;
  typedef enum logic [1:0] {LA_CUR, LA_FREE, LA_PREV, LA_POS} lk_addr_t;
  typedef enum logic [2:0] {LD_INC, LD_FREE, LD_SAV, LD_END, LD_CUR, LD_LINK} lk_data_t;
  typedef enum logic {VA_FREE, VA_POS} va_addr_t;
  typedef enum logic {VD_SAV, VD_IN} va_data_t;
  typedef enum logic [1:0] {HD_HOLD, HD_FREE, HD_LINK, HD_END} head_sel_t;
  typedef enum logic [1:0] {FR_HOLD, FR_LINK, FR_CUR, FR_POS} free_sel_t;
  typedef enum logic [2:0] {RP_ZERO, RP_END, RP_POS, RP_PREV, RP_LINK} rpos_sel_t;

  typedef struct packed {
    logic            in_ld;
    cur_sel_t        cur_sel;
    rd_sel_t         rd_sel;
    logic            found_clr;
    logic            prev_ld;
    logic            sav_ld;
    logic            lk_we;
    lk_addr_t        lk_addr;
    lk_data_t        lk_data;
    logic            va_we;
    va_addr_t        va_addr;
    va_data_t        va_data;
    head_sel_t       head_sel;
    free_sel_t       free_sel;
    logic            res_ld;
    rpos_sel_t       res_pos;
    logic            res_val_rd;
    logic [ST_W-1:0] res_st;
    logic            out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            head_end;
    logic            free_end;
    logic            pos_end;
    logic            pos_in_range;
    logic            pos_eq_head;
    logic            found;
    logic            link_hit;
    logic            link_end;
    logic            val_hit;
    logic            init_last;
    logic            out_free;
  } dp_stat_t;

endpackage

[rtl/cursor_linked_list_free_pool_unit.sv]
// ----------------------------------------------------------------------------
// cursor_linked_list_free_pool_unit
// Singly linked list of values in a fixed node pool with a free list.
// ----------------------------------------------------------------------------
// After reset the unit chains the pool into the free list and holds
// in_ready low meanwhile. It then takes one item at a time. Each item
// walks the list from the head, visiting up to the list length (at most
// NODES) nodes; insert, delete, retrieve and next then run further update
// steps, while locate, prev, clear and the failing cases finish after the
// walk. The walk reads the link memory once per cycle through its single
// read port. A finished result sits in an output register, so the next item
// is accepted while that result waits.
module cursor_linked_list_free_pool_unit #(
  parameter int  NODES      = 256,
  parameter int  DATA_WIDTH = 32,
  localparam int PW         = $clog2(NODES + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [clfp_pkg::OP_W-1:0] in_opcode,
  input  logic [PW-1:0]             in_position,
  input  logic [DATA_WIDTH-1:0]     in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [PW-1:0]             out_result_position,
  output logic [DATA_WIDTH-1:0]     out_result_value,
  output logic [clfp_pkg::ST_W-1:0] out_status,
  output logic [PW-1:0]             out_first_position
);
  import clfp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  clfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // memories and registers
  clfp_dp #(.NODES(NODES), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_opcode           (in_opcode),
    .in_position         (in_position),
    .in_value            (in_value),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_result_position (out_result_position),
    .out_result_value    (out_result_value),
    .out_status          (out_status),
    .out_first_position  (out_first_position)
  );

endmodule

[rtl/clfp_ram.sv]
// ----------------------------------------------------------------------------
// clfp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module clfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/clfp_ctrl.sv]
// ----------------------------------------------------------------------------
// clfp_ctrl
// Sequencer of the free pool unit: link init sweep, list walks and the
// per-opcode update steps, driving the datapath by command struct.
// ----------------------------------------------------------------------------
module clfp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  clfp_pkg::dp_stat_t stat,
  output clfp_pkg::dp_cmd_t  cmd
);
  import clfp_pkg::*;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_WALK  = 4'd3;
  localparam logic [3:0] S_POST  = 4'd4;
  localparam logic [3:0] S_INS_Q = 4'd5;
  localparam logic [3:0] S_INS_F = 4'd6;
  localparam logic [3:0] S_INS_A = 4'd7;
  localparam logic [3:0] S_INS_M = 4'd8;
  localparam logic [3:0] S_DEL1  = 4'd9;
  localparam logic [3:0] S_DEL2  = 4'd10;
  localparam logic [3:0] S_RET   = 4'd11;
  localparam logic [3:0] S_NXT   = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       member;
  logic       ins_ok;
  logic       mid_ins;
  logic       walk_hit;

  // membership and hit terms
  assign member  = stat.pos_in_range && (stat.pos_eq_head || stat.found);
  assign ins_ok  = stat.head_end || (stat.pos_end ? stat.found : member);
  assign mid_ins = !stat.head_end && !stat.pos_end;

  always_comb begin
    walk_hit = stat.link_hit;
    if (stat.op == OP_LOCATE) begin
      walk_hit = stat.val_hit;
    end else if (stat.op == OP_CLEAR) begin
      walk_hit = 1'b0;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd.in_ld      = 1'b0;
    cmd.cur_sel    = CUR_HOLD;
    cmd.rd_sel     = RA_HEAD;
    cmd.found_clr  = 1'b0;
    cmd.prev_ld    = 1'b0;
    cmd.sav_ld     = 1'b0;
    cmd.lk_we      = 1'b0;
    cmd.lk_addr    = LA_CUR;
    cmd.lk_data    = LD_INC;
    cmd.va_we      = 1'b0;
    cmd.va_addr    = VA_FREE;
    cmd.va_data    = VD_IN;
    cmd.head_sel   = HD_HOLD;
    cmd.free_sel   = FR_HOLD;
    cmd.res_ld     = 1'b0;
    cmd.res_pos    = RP_ZERO;
    cmd.res_val_rd = 1'b0;
    cmd.res_st     = ST_OK;
    cmd.out_ld     = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.lk_we   = 1'b1;
        cmd.lk_addr = LA_CUR;
        cmd.lk_data = LD_INC;
        cmd.cur_sel = CUR_INC;
        if (stat.init_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_ld = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.cur_sel   = CUR_HEAD;
        cmd.rd_sel    = RA_HEAD;
        cmd.found_clr = 1'b1;
        if (stat.head_end || stat.op == OP_RSVD) begin
          state_nxt = S_POST;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        // clear pushes each visited node onto the free list
        if (stat.op == OP_CLEAR) begin
          cmd.lk_we    = 1'b1;
          cmd.lk_addr  = LA_CUR;
          cmd.lk_data  = LD_FREE;
          cmd.free_sel = FR_CUR;
        end
        if (walk_hit) begin
          cmd.prev_ld = 1'b1;
          state_nxt   = S_POST;
        end else if (stat.link_end) begin
          state_nxt = S_POST;
        end else begin
          cmd.cur_sel = CUR_LINK;
          cmd.rd_sel  = RA_LINK;
        end
      end
      S_POST: begin
        cmd.res_ld = 1'b1;
        state_nxt  = S_FIN;
        unique case (stat.op)
          OP_INSERT: begin
            if (!ins_ok) begin
              cmd.res_st = ST_BAD_POS;
            end else if (stat.free_end) begin
              cmd.res_st = ST_POOL_FULL;
            end else if (mid_ins) begin
              cmd.rd_sel = RA_POS;
              state_nxt  = S_INS_Q;
            end else begin
              cmd.rd_sel = RA_FREE;
              state_nxt  = S_INS_F;
            end
          end
          OP_DELETE: begin
            if (!member) begin
              cmd.res_pos = RP_POS;
              cmd.res_st  = ST_BAD_POS;
            end else begin
              cmd.rd_sel = RA_POS;
              state_nxt  = S_DEL1;
            end
          end
          OP_LOCATE: begin
            if (stat.found) begin
              cmd.res_pos = RP_PREV;
            end else begin
              cmd.res_pos = RP_END;
              cmd.res_st  = ST_NOT_FOUND;
            end
          end
          OP_RETRIEVE: begin
            if (member) begin
              cmd.rd_sel = RA_POS;
              state_nxt  = S_RET;
            end else begin
              cmd.res_st = ST_BAD_POS;
            end
          end
          OP_NEXT: begin
            if (member) begin
              cmd.rd_sel = RA_POS;
              state_nxt  = S_NXT;
            end else begin
              cmd.res_pos = RP_END;
              cmd.res_st  = ST_BAD_POS;
            end
          end
          OP_PREV: begin
            if (!stat.pos_eq_head && (stat.pos_in_range || stat.pos_end) && stat.found) begin
              cmd.res_pos = RP_PREV;
            end else begin
              cmd.res_pos = RP_END;
              cmd.res_st  = ST_BAD_POS;
            end
          end
          OP_CLEAR: begin
            cmd.head_sel = HD_END;
          end
          default: begin
            cmd.res_pos = RP_END;
          end
        endcase
      end
      S_INS_Q: begin
        cmd.sav_ld = 1'b1;
        cmd.rd_sel = RA_FREE;
        state_nxt  = S_INS_F;
      end
      S_INS_F: begin
        // take the free node and fill it
        cmd.cur_sel  = CUR_FREE;
        cmd.free_sel = FR_LINK;
        cmd.va_we    = 1'b1;
        cmd.va_addr  = VA_FREE;
        cmd.va_data  = mid_ins ? VD_SAV : VD_IN;
        cmd.lk_we    = 1'b1;
        cmd.lk_addr  = LA_FREE;
        cmd.lk_data  = mid_ins ? LD_SAV : LD_END;
        if (stat.head_end) begin
          cmd.head_sel = HD_FREE;
          state_nxt    = S_FIN;
        end else if (stat.pos_end) begin
          state_nxt = S_INS_A;
        end else begin
          state_nxt = S_INS_M;
        end
      end
      S_INS_A: begin
        cmd.lk_we   = 1'b1;
        cmd.lk_addr = LA_PREV;
        cmd.lk_data = LD_CUR;
        state_nxt   = S_FIN;
      end
      S_INS_M: begin
        cmd.lk_we   = 1'b1;
        cmd.lk_addr = LA_POS;
        cmd.lk_data = LD_CUR;
        cmd.va_we   = 1'b1;
        cmd.va_addr = VA_POS;
        cmd.va_data = VD_IN;
        state_nxt   = S_FIN;
      end
      S_DEL1: begin
        // unlink the node, its successor is the result
        if (stat.pos_eq_head) begin
          cmd.head_sel = HD_LINK;
        end else begin
          cmd.lk_we   = 1'b1;
          cmd.lk_addr = LA_PREV;
          cmd.lk_data = LD_LINK;
        end
        cmd.res_ld  = 1'b1;
        cmd.res_pos = RP_LINK;
        state_nxt   = S_DEL2;
      end
      S_DEL2: begin
        cmd.lk_we    = 1'b1;
        cmd.lk_addr  = LA_POS;
        cmd.lk_data  = LD_FREE;
        cmd.free_sel = FR_POS;
        state_nxt    = S_FIN;
      end
      S_RET: begin
        cmd.res_ld     = 1'b1;
        cmd.res_val_rd = 1'b1;
        state_nxt      = S_FIN;
      end
      S_NXT: begin
        cmd.res_ld  = 1'b1;
        cmd.res_pos = RP_LINK;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/clfp_dp.sv]
// ----------------------------------------------------------------------------
// clfp_dp
// Datapath of the free pool unit: link and value memories, head, free head,
// walk cursor, result registers and the output register.
// ----------------------------------------------------------------------------
module clfp_dp #(
  parameter int  NODES      = 256,
  parameter int  DATA_WIDTH = 32,
  localparam int PW         = $clog2(NODES + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  clfp_pkg::dp_cmd_t            cmd,
  output clfp_pkg::dp_stat_t           stat,
  input  logic [clfp_pkg::OP_W-1:0]    in_opcode,
  input  logic [PW-1:0]                in_position,
  input  logic [DATA_WIDTH-1:0]        in_value,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [PW-1:0]                out_result_position,
  output logic [DATA_WIDTH-1:0]        out_result_value,
  output logic [clfp_pkg::ST_W-1:0]    out_status,
  output logic [PW-1:0]                out_first_position
);
  import clfp_pkg::*;

  localparam int            AW       = $clog2(NODES);
  localparam logic [PW-1:0] END_POS  = PW'(NODES);
  localparam logic [PW-1:0] LAST_IDX = PW'(NODES - 1);

  logic [OP_W-1:0]       op_r;
  logic [PW-1:0]         pos_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [PW-1:0]         head_r, head_nxt;
  logic [PW-1:0]         free_r, free_nxt;
  logic [PW-1:0]         cur_r, cur_nxt;
  logic [PW-1:0]         prev_r;
  logic                  found_r;
  logic [PW-1:0]         savl_r;
  logic [DATA_WIDTH-1:0] savv_r;
  logic [PW-1:0]         rpos_r, rpos_nxt;
  logic [DATA_WIDTH-1:0] rval_r;
  logic [ST_W-1:0]       rst_r;
  logic                  out_valid_r;
  logic [PW-1:0]         out_rpos_r;
  logic [DATA_WIDTH-1:0] out_rval_r;
  logic [ST_W-1:0]       out_st_r;
  logic [PW-1:0]         out_first_r;

  logic [PW-1:0]         rd_link;
  logic [DATA_WIDTH-1:0] rd_val;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         lk_waddr;
  logic [PW-1:0]         lk_wdata;
  logic [AW-1:0]         va_waddr;
  logic [DATA_WIDTH-1:0] va_wdata;
  logic [PW-1:0]         cur_inc;

  assign cur_inc = cur_r + PW'(1);

  // memory address and data selection
  always_comb begin
    unique case (cmd.rd_sel)
      RA_HEAD: rd_addr = head_r[AW-1:0];
      RA_LINK: rd_addr = rd_link[AW-1:0];
      RA_POS:  rd_addr = pos_r[AW-1:0];
      RA_FREE: rd_addr = free_r[AW-1:0];
      default: rd_addr = head_r[AW-1:0];
    endcase
    unique case (cmd.lk_addr)
      LA_CUR:  lk_waddr = cur_r[AW-1:0];
      LA_FREE: lk_waddr = free_r[AW-1:0];
      LA_PREV: lk_waddr = prev_r[AW-1:0];
      LA_POS:  lk_waddr = pos_r[AW-1:0];
      default: lk_waddr = cur_r[AW-1:0];
    endcase
    unique case (cmd.lk_data)
      LD_INC:  lk_wdata = cur_inc;
      LD_FREE: lk_wdata = free_r;
      LD_SAV:  lk_wdata = savl_r;
      LD_END:  lk_wdata = END_POS;
      LD_CUR:  lk_wdata = cur_r;
      LD_LINK: lk_wdata = rd_link;
      default: lk_wdata = END_POS;
    endcase
    va_waddr = (cmd.va_addr == VA_POS) ? pos_r[AW-1:0] : free_r[AW-1:0];
    va_wdata = (cmd.va_data == VD_SAV) ? savv_r : val_r;
  end

  clfp_ram #(.WIDTH(PW), .DEPTH(NODES)) u_link_ram (
    .clk   (clk),
    .we    (cmd.lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (rd_addr),
    .rdata (rd_link)
  );

  clfp_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NODES)) u_value_ram (
    .clk   (clk),
    .we    (cmd.va_we),
    .waddr (va_waddr),
    .wdata (va_wdata),
    .raddr (rd_addr),
    .rdata (rd_val)
  );

  // next values of the pointer registers
  always_comb begin
    unique case (cmd.cur_sel)
      CUR_HOLD: cur_nxt = cur_r;
      CUR_HEAD: cur_nxt = head_r;
      CUR_INC:  cur_nxt = cur_inc;
      CUR_LINK: cur_nxt = rd_link;
      CUR_FREE: cur_nxt = free_r;
      default:  cur_nxt = cur_r;
    endcase
    unique case (cmd.head_sel)
      HD_HOLD: head_nxt = head_r;
      HD_FREE: head_nxt = free_r;
      HD_LINK: head_nxt = rd_link;
      HD_END:  head_nxt = END_POS;
      default: head_nxt = head_r;
    endcase
    unique case (cmd.free_sel)
      FR_HOLD: free_nxt = free_r;
      FR_LINK: free_nxt = rd_link;
      FR_CUR:  free_nxt = cur_r;
      FR_POS:  free_nxt = pos_r;
      default: free_nxt = free_r;
    endcase
    unique case (cmd.res_pos)
      RP_ZERO: rpos_nxt = '0;
      RP_END:  rpos_nxt = END_POS;
      RP_POS:  rpos_nxt = pos_r;
      RP_PREV: rpos_nxt = prev_r;
      RP_LINK: rpos_nxt = rd_link;
      default: rpos_nxt = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= END_POS;
      free_r      <= '0;
      cur_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      free_r <= free_nxt;
      cur_r  <= cur_nxt;
      if (cmd.found_clr) begin
        found_r <= 1'b0;
      end else if (cmd.prev_ld) begin
        found_r <= 1'b1;
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.in_ld) begin
      op_r  <= in_opcode;
      pos_r <= in_position;
      val_r <= in_value;
    end
    if (cmd.prev_ld) begin
      prev_r <= cur_r;
    end
    if (cmd.sav_ld) begin
      savl_r <= rd_link;
      savv_r <= rd_val;
    end
    if (cmd.res_ld) begin
      rpos_r <= rpos_nxt;
      rval_r <= cmd.res_val_rd ? rd_val : '0;
      rst_r  <= cmd.res_st;
    end
    if (cmd.out_ld) begin
      out_rpos_r  <= rpos_r;
      out_rval_r  <= rval_r;
      out_st_r    <= rst_r;
      out_first_r <= head_r;
    end
  end

  // status to the controller
  assign stat.op           = op_r;
  assign stat.head_end     = (head_r == END_POS);
  assign stat.free_end     = (free_r == END_POS);
  assign stat.pos_end      = (pos_r == END_POS);
  assign stat.pos_in_range = (pos_r < END_POS);
  assign stat.pos_eq_head  = (pos_r == head_r);
  assign stat.found        = found_r;
  assign stat.link_hit     = (rd_link == pos_r);
  assign stat.link_end     = (rd_link == END_POS);
  assign stat.val_hit      = (rd_val == val_r);
  assign stat.init_last    = (cur_r == LAST_IDX);
  assign stat.out_free     = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_result_position = out_rpos_r;
  assign out_result_value    = out_rval_r;
  assign out_status          = out_st_r;
  assign out_first_position  = out_first_r;

endmodule

[rtl/clfp_checker.sv]
// ----------------------------------------------------------------------------
// clfp_checker
// Port level checks of the free pool unit, bound to the top level.
// ----------------------------------------------------------------------------
module clfp_checker #(
  parameter int  NODES      = 256,
  parameter int  DATA_WIDTH = 32,
  localparam int PW         = $clog2(NODES + 1)
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [PW-1:0]             out_result_position,
  input logic [DATA_WIDTH-1:0]     out_result_value,
  input logic [clfp_pkg::ST_W-1:0] out_status,
  input logic [PW-1:0]             out_first_position
);
  import clfp_pkg::*;

  // one item at a time: ready drops after an input beat
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an input beat");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_position)
      && $stable(out_status) && $stable(out_first_position))
    else $error("result beat changed while stalled");

  // a failed locate reports the end marker
  a_not_found_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NOT_FOUND |-> out_result_position == PW'(NODES))
    else $error("not found without end marker");

  // value is zero unless the operation succeeded
  a_err_zero_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_result_value == '0)
    else $error("nonzero value on error");

  // head never beyond the end marker
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_first_position <= PW'(NODES))
    else $error("head position out of range");

endmodule

bind cursor_linked_list_free_pool_unit clfp_checker #(
  .NODES(NODES),
  .DATA_WIDTH(DATA_WIDTH)
) u_clfp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_result_position (out_result_position),
  .out_result_value    (out_result_value),
  .out_status          (out_status),
  .out_first_position  (out_first_position)
);

[verif/tb_cursor_linked_list_free_pool_unit.sv]
// ----------------------------------------------------------------------------
// tb_cursor_linked_list_free_pool_unit
// Self-checking bench for the linked list free pool unit. A queue of command
// beats feeds a clocked driver. A clocked monitor checks every result beat
// against a behavioral list model that keeps its own node pool and free list.
// ----------------------------------------------------------------------------
module tb_cursor_linked_list_free_pool_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import clfp_pkg::*;

  localparam int NODES = 256;
  localparam int PW = 9;
  localparam logic [PW-1:0] END_POS = 9'd256;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic [PW-1:0]   position;
    logic [31:0]     value;
  } list_cmd_t;

  typedef struct packed {
    logic [PW-1:0]   rpos;
    logic [31:0]     rval;
    logic [ST_W-1:0] status;
    logic [PW-1:0]   first;
  } list_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_opcode = '0;
  logic [PW-1:0] in_position = '0;
  logic [31:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PW-1:0] out_result_position;
  logic [31:0] out_result_value;
  logic [ST_W-1:0] out_status;
  logic [PW-1:0] out_first_position;

  cursor_linked_list_free_pool_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .in_position(in_position), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_position(out_result_position), .out_result_value(out_result_value),
    .out_status(out_status), .out_first_position(out_first_position)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // pool model state
  logic [PW-1:0] mdl_link [NODES];
  logic [31:0]   mdl_val [NODES];
  logic [PW-1:0] mdl_free;
  logic [PW-1:0] mdl_head;

  list_cmd_t cmd_q[$];
  list_rsp_t want_q[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int hold_off = 0;
  bit pause_drv = 1'b0;

  function automatic bit find_pred(input logic [PW-1:0] p, output logic [PW-1:0] pred);
    logic [PW-1:0] cur;
    cur = mdl_head;
    pred = '0;
    for (int n = 0; n < NODES && cur < NODES; n++) begin
      if (mdl_link[cur] == p) begin
        pred = cur;
        return 1'b1;
      end
      cur = mdl_link[cur];
    end
    return 1'b0;
  endfunction

  function automatic bit listed(input logic [PW-1:0] p);
    logic [PW-1:0] d;
    if (p >= NODES) return 1'b0;
    if (p == mdl_head) return 1'b1;
    return find_pred(p, d);
  endfunction

  function automatic logic [PW-1:0] pop_free();
    logic [PW-1:0] n;
    n = mdl_free;
    mdl_free = (n < NODES) ? mdl_link[n] : END_POS;
    return n;
  endfunction

  // apply one command to the model and return its expected result
  function automatic list_rsp_t apply_list_op(input list_cmd_t c);
    list_rsp_t r;
    logic [PW-1:0] p, pr, n, cur;
    r = '0;
    p = c.position;
    case (c.opcode)
      OP_INSERT: begin
        if (mdl_head == END_POS) begin
          if (mdl_free >= NODES) r.status = ST_POOL_FULL;
          else begin
            n = pop_free();
            mdl_val[n] = c.value;
            mdl_link[n] = END_POS;
            mdl_head = n;
          end
        end else if (p == END_POS) begin
          if (mdl_free >= NODES) r.status = ST_POOL_FULL;
          else if (!find_pred(END_POS, pr)) r.status = ST_BAD_POS;
          else begin
            n = pop_free();
            mdl_val[n] = c.value;
            mdl_link[n] = END_POS;
            mdl_link[pr] = n;
          end
        end else if (listed(p)) begin
          if (mdl_free >= NODES) r.status = ST_POOL_FULL;
          else begin
            n = pop_free();
            mdl_val[n] = mdl_val[p];
            mdl_link[n] = mdl_link[p];
            mdl_val[p] = c.value;
            mdl_link[p] = n;
          end
        end else r.status = ST_BAD_POS;
      end
      OP_DELETE: begin
        if (!listed(p)) begin
          r.status = ST_BAD_POS;
          r.rpos = p;
        end else begin
          n = mdl_link[p];
          if (p == mdl_head) mdl_head = n;
          else if (find_pred(p, pr)) mdl_link[pr] = n;
          mdl_link[p] = mdl_free;
          mdl_free = p;
          r.rpos = n;
        end
      end
      OP_LOCATE: begin
        r.rpos = END_POS;
        r.status = ST_NOT_FOUND;
        cur = mdl_head;
        for (int k = 0; k < NODES && cur < NODES; k++) begin
          if (mdl_val[cur] == c.value) begin
            r.rpos = cur;
            r.status = ST_OK;
            break;
          end
          cur = mdl_link[cur];
        end
      end
      OP_RETRIEVE: begin
        if (listed(p)) r.rval = mdl_val[p];
        else r.status = ST_BAD_POS;
      end
      OP_NEXT: begin
        if (listed(p)) r.rpos = mdl_link[p];
        else begin
          r.status = ST_BAD_POS;
          r.rpos = END_POS;
        end
      end
      OP_PREV: begin
        if (p != mdl_head && (p < NODES || p == END_POS) && find_pred(p, pr)) r.rpos = pr;
        else begin
          r.status = ST_BAD_POS;
          r.rpos = END_POS;
        end
      end
      OP_CLEAR: begin
        cur = mdl_head;
        for (int k = 0; k < NODES && cur < NODES; k++) begin
          n = mdl_link[cur];
          mdl_link[cur] = mdl_free;
          mdl_free = cur;
          cur = n;
        end
        mdl_head = END_POS;
      end
      default: r.rpos = END_POS;
    endcase
    r.first = mdl_head;
    return r;
  endfunction

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // position biased toward list members and the end marker
  function automatic logic [PW-1:0] pick_pos();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return END_POS;
    if (roll < 25) return PW'($urandom_range(0, 511));
    if (roll < 35) return mdl_head;
    return PW'($urandom_range(0, 40));
  endfunction

  task automatic push_cmd(input logic [OP_W-1:0] op, input logic [PW-1:0] p,
                          input logic [31:0] v);
    list_cmd_t c;
    c.opcode = op;
    c.position = p;
    c.value = v;
    cmd_q.push_back(c);
  endtask

  // driver: command beats out of the queue with random gaps
  int drv_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        want_q.push_back(apply_list_op({in_opcode, in_position, in_value}));
        drv_gap = gap_len();
      end
      if (!in_valid || in_ready) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_valid <= 1'b0;
        end else if (cmd_q.size() > 0 && !pause_drv) begin
          in_valid <= 1'b1;
          in_opcode <= cmd_q[0].opcode;
          in_position <= cmd_q[0].position;
          in_value <= cmd_q[0].value;
          void'(cmd_q.pop_front());
        end else in_valid <= 1'b0;
      end
    end
  end

  // monitor: check result beats, stall the receiver at random
  int rcv_gap = 0;
  always @(posedge clk) begin
    list_rsp_t got, exp_rsp;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_result_position, out_result_value, out_status, out_first_position};
        if (want_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", got);
        end else begin
          exp_rsp = want_q.pop_front();
          if (got !== exp_rsp) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected pos %0d val %h st %0d head %0d,",
                        " got pos %0d val %h st %0d head %0d"},
                       exp_rsp.rpos, exp_rsp.rval, exp_rsp.status, exp_rsp.first,
                       got.rpos, got.rval, got.status, got.first);
          end
        end
        rcv_gap = gap_len();
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else if (rcv_gap > 0) begin
        rcv_gap--;
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] vals[4];
    int op_roll;
    for (int i = 0; i < NODES; i++) begin
      mdl_link[i] = PW'(i + 1);
      mdl_val[i] = '0;
    end
    mdl_free = '0;
    mdl_head = END_POS;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty-list cases, extremes, every opcode
    push_cmd(OP_RETRIEVE, 9'd0, 32'd0);
    push_cmd(OP_PREV, END_POS, 32'd0);
    push_cmd(OP_DELETE, END_POS, 32'd0);
    push_cmd(OP_LOCATE, 9'd0, 32'hFFFF_FFFF);
    push_cmd(OP_INSERT, 9'd511, 32'hFFFF_FFFF);
    push_cmd(OP_INSERT, END_POS, 32'd0);
    push_cmd(OP_INSERT, 9'd0, 32'hA5A5_5A5A);
    push_cmd(OP_INSERT, 9'd300, 32'd1);
    push_cmd(OP_LOCATE, 9'd0, 32'd0);
    push_cmd(OP_RETRIEVE, 9'd1, 32'd0);
    push_cmd(OP_NEXT, 9'd0, 32'd0);
    push_cmd(OP_NEXT, END_POS, 32'd0);
    push_cmd(OP_PREV, END_POS, 32'd0);
    push_cmd(OP_PREV, 9'd0, 32'd0);
    push_cmd(OP_PREV, 9'd511, 32'd0);
    push_cmd(OP_DELETE, END_POS, 32'd0);
    push_cmd(OP_DELETE, 9'd255, 32'd0);
    push_cmd(OP_DELETE, 9'd0, 32'd0);
    push_cmd(OP_RSVD, 9'd5, 32'h1234_5678);
    push_cmd(OP_CLEAR, 9'd0, 32'd0);
    push_cmd(OP_NEXT, 9'd0, 32'd0);

    // fill the pool to the top, then pool-full inserts
    for (int i = 0; i < NODES; i++) push_cmd(OP_INSERT, END_POS, $urandom);
    push_cmd(OP_INSERT, END_POS, 32'd7);
    push_cmd(OP_INSERT, 9'd255, 32'd7);
    push_cmd(OP_PREV, END_POS, 32'd0);
    push_cmd(OP_CLEAR, 9'd0, 32'd0);

    // long receiver hold while the sender keeps offering
    wait (cmd_q.size() < 200);
    hold_off = 300;
    wait (cmd_q.size() == 0);
    // sender pause until all results drained
    pause_drv = 1'b1;
    wait (want_q.size() == 0 && !in_valid);
    pause_drv = 1'b0;

    // random: mostly well-formed list work with a small value alphabet
    for (int i = 0; i < 4; i++) vals[i] = $urandom;
    for (int i = 0; i < 820; i++) begin
      wait (cmd_q.size() < 4);
      op_roll = $urandom_range(0, 99);
      if (op_roll < 35)
        push_cmd(OP_INSERT, pick_pos(),
                 ($urandom_range(0, 1)) ? vals[$urandom_range(0, 3)] : $urandom);
      else if (op_roll < 50) push_cmd(OP_DELETE, pick_pos(), $urandom);
      else if (op_roll < 62)
        push_cmd(OP_LOCATE, pick_pos(),
                 ($urandom_range(0, 2) > 0) ? vals[$urandom_range(0, 3)] : $urandom);
      else if (op_roll < 74) push_cmd(OP_RETRIEVE, pick_pos(), $urandom);
      else if (op_roll < 85) push_cmd(OP_NEXT, pick_pos(), $urandom);
      else if (op_roll < 96) push_cmd(OP_PREV, pick_pos(), $urandom);
      else if (op_roll < 98) push_cmd(OP_CLEAR, pick_pos(), $urandom);
      else push_cmd(OP_RSVD, pick_pos(), $urandom);
    end

    wait (cmd_q.size() == 0 && !in_valid);
    wait (want_q.size() == 0);
    repeat (600) @(posedge clk);
    if (mismatches == 0 && want_q.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

[sim.f]
rtl/clfp_pkg.sv
rtl/clfp_ram.sv
rtl/clfp_ctrl.sv
rtl/clfp_dp.sv
rtl/cursor_linked_list_free_pool_unit.sv
rtl/clfp_checker.sv
verif/tb_cursor_linked_list_free_pool_unit.sv
